[rtl/kdpi_pkg.sv]
`timescale 1ns / 1ps

package kdpi_pkg;

	// Item codes on the query channel.
	localparam logic OP_QUERY = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// Fixed field widths.
	localparam int RADIUS_W = 16;
	localparam int LIMIT_W  = 7;
	localparam int SQ_W     = 2 * RADIUS_W;

	// Node limit after reset.
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd64;

	// Squared axis distances of one node, with a flag for an axis gap that
	// alone already exceeds any margin.
	typedef struct packed {
		logic            far;
		logic [SQ_W-1:0] sq_x;
		logic [SQ_W-1:0] sq_y;
		logic [SQ_W-1:0] sq_z;
	} dist_t;

endpackage

[rtl/kdpi_if.sv]
`timescale 1ns / 1ps

// Query word: one point and its margin, or a clear command.
interface kdpi_query_if #(
	parameter int COORD_BITS = 16
);
	logic                             valid;
	logic                             ready;
	logic                             opcode;
	logic signed [COORD_BITS-1:0]     point_x;
	logic signed [COORD_BITS-1:0]     point_y;
	logic signed [COORD_BITS-1:0]     point_z;
	logic [kdpi_pkg::RADIUS_W-1:0]    radius;

	modport source (output valid, opcode, point_x, point_y, point_z, radius, input ready);
	modport sink   (input valid, opcode, point_x, point_y, point_z, radius, output ready);
endinterface

// Result word: one per query word.
interface kdpi_result_if;
	logic valid;
	logic ready;
	logic near_found;
	logic was_inserted;
	logic store_full;

	modport source (output valid, near_found, was_inserted, store_full, input ready);
	modport sink   (input valid, near_found, was_inserted, store_full, output ready);
endinterface

// Configuration word: the node limit.
interface kdpi_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [kdpi_pkg::LIMIT_W-1:0] node_limit;

	modport source (output valid, node_limit, input ready);
	modport sink   (input valid, node_limit, output ready);
endinterface

[rtl/kd_tree_proximity_insert_top.sv]
`timescale 1ns / 1ps

// 3-D k-d tree with proximity check and insert.
// Channels: query (sink) takes a clear word or a point with a margin; result
// (source) returns one word per query word; cfg (sink) writes the node limit
// and is always ready. Words move when valid and ready are both high.
// A clear word, a refused word (store full) and the first point of an empty
// tree answer in the cycle after acceptance. Otherwise the tree is walked from
// the root one node at a time: the node is read from the node RAM (READ), its
// distance squares are registered and the walk then decides (DECIDE); a point
// attached as a new leaf has its parent linked in a further LINK state. The
// single RAM read port and the read-square-decide loop set the pace of the
// walk; one query is in work at a time.
// Reset empties the tree and sets the node limit to 64; the node RAM needs no
// clearing pass since only entries below the node count are ever read.
// While the result word is not taken, the block holds its answer, and the next
// query word is taken in the same cycle that the waiting result is taken.
module kd_tree_proximity_insert_top #(
	parameter int MAX_NODES  = 64,
	parameter int COORD_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	kdpi_query_if.sink          query,
	kdpi_result_if.source       result,
	kdpi_cfg_if.sink            cfg
);

	localparam int IDX_W   = $clog2(MAX_NODES);
	localparam int CNT_W   = $clog2(MAX_NODES + 1);
	localparam int LW      = kdpi_pkg::LIMIT_W;
	localparam int CMP_W   = (CNT_W > LW) ? CNT_W : LW;
	localparam int CB      = COORD_BITS;
	localparam int ENTRY_W = 3 * CB + 2 * IDX_W;
	localparam int SUM_W   = kdpi_pkg::SQ_W + 2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_DECIDE,
		S_LINK
	} state_t;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	// Entry layout: x, y, z, left, right from the top down.
	function automatic logic signed [CB-1:0] ent_coord(input logic [ENTRY_W-1:0] e,
			input int k);
		logic [ENTRY_W-1:0] sh;
		sh = e >> (2 * IDX_W + (2 - k) * CB);
		return sh[CB-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] ent_left(input logic [ENTRY_W-1:0] e);
		return e[2*IDX_W-1:IDX_W];
	endfunction

	function automatic logic [IDX_W-1:0] ent_right(input logic [ENTRY_W-1:0] e);
		return e[IDX_W-1:0];
	endfunction

	state_t                      state_q;
	axis_t                       axis_q;
	logic [LW-1:0]               node_limit_q;
	logic [CNT_W-1:0]            count_q;
	logic [IDX_W-1:0]            node_q;
	logic signed [CB-1:0]        px_q, py_q, pz_q;
	logic [kdpi_pkg::SQ_W-1:0]   radius_sq_q;
	logic [ENTRY_W-1:0]          entry_q;
	logic                        go_left_q;
	logic                        out_valid_q, near_q, ins_q, full_q;

	logic                        out_free, in_ready, accept;
	logic [CMP_W-1:0]            limit_ext, limit_cap, count_ext;
	logic                        is_full;
	logic                        wr_en, rd_en;
	logic [IDX_W-1:0]            wr_addr, rd_addr;
	logic [ENTRY_W-1:0]          wr_data, rd_data;
	logic signed [CB-1:0]        e_x, e_y, e_z;
	logic signed [CB-1:0]        p_axis, e_axis;
	kdpi_pkg::dist_t             dist_s1;
	logic [SUM_W-1:0]            dist_sum;
	logic                        near_hit;
	logic [IDX_W-1:0]            link;
	logic                        res_load;

	// Handshake and fill state.
	always_comb begin
		out_free  = !out_valid_q || result.ready;
		in_ready  = (state_q == S_IDLE) && out_free;
		accept    = query.valid && in_ready;
		limit_ext = CMP_W'(node_limit_q);
		limit_cap = (limit_ext > CMP_W'(MAX_NODES)) ? CMP_W'(MAX_NODES) : limit_ext;
		count_ext = CMP_W'(count_q);
		is_full   = count_ext >= limit_cap;
	end

	assign query.ready         = in_ready;
	assign cfg.ready           = 1'b1;
	assign result.valid        = out_valid_q;
	assign result.near_found   = near_q;
	assign result.was_inserted = ins_q;
	assign result.store_full   = full_q;

	// Node fields straight from the RAM read.
	always_comb begin
		e_x = ent_coord(rd_data, 0);
		e_y = ent_coord(rd_data, 1);
		e_z = ent_coord(rd_data, 2);
		unique case (axis_q)
			AXIS_X: begin
				p_axis = px_q;
				e_axis = e_x;
			end
			AXIS_Y: begin
				p_axis = py_q;
				e_axis = e_y;
			end
			AXIS_Z: begin
				p_axis = pz_q;
				e_axis = e_z;
			end
			default: begin
				p_axis = px_q;
				e_axis = e_x;
			end
		endcase
	end

	kdpi_dist #(
		.COORD_BITS (CB)
	) u_dist (
		.clk     (clk),
		.p_x     (px_q),
		.p_y     (py_q),
		.p_z     (pz_q),
		.e_x     (e_x),
		.e_y     (e_y),
		.e_z     (e_z),
		.dist_s1 (dist_s1)
	);

	// Proximity test and the child link on the descent side.
	always_comb begin
		dist_sum = SUM_W'(dist_s1.sq_x) + SUM_W'(dist_s1.sq_y) + SUM_W'(dist_s1.sq_z);
		near_hit = !dist_s1.far && (dist_sum < SUM_W'(radius_sq_q));
		link     = go_left_q ? ent_left(entry_q) : ent_right(entry_q);
	end

	// A new result word is loaded into the output register this cycle.
	always_comb begin
		unique case (state_q)
			S_IDLE: begin
				res_load = accept && ((query.opcode == kdpi_pkg::OP_CLEAR) || is_full ||
					(count_q == '0));
			end
			S_DECIDE: begin
				res_load = near_hit && out_free;
			end
			S_LINK: begin
				res_load = out_free;
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	// Node RAM access.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[IDX_W-1:0];
		wr_data = {px_q, py_q, pz_q, {(2 * IDX_W){1'b0}}};
		rd_en   = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (query.opcode == kdpi_pkg::OP_QUERY) && !is_full) begin
					if (count_q == '0) begin
						// First point becomes the root.
						wr_en   = 1'b1;
						wr_addr = '0;
						wr_data = {query.point_x, query.point_y, query.point_z,
							{(2 * IDX_W){1'b0}}};
					end else begin
						rd_en = 1'b1;
					end
				end
			end
			S_DECIDE: begin
				if (!near_hit) begin
					if (link == '0) begin
						// New leaf at the next free entry.
						wr_en = 1'b1;
					end else begin
						rd_en   = 1'b1;
						rd_addr = link;
					end
				end
			end
			S_LINK: begin
				// Parent gets the link to the new leaf.
				wr_en   = out_free;
				wr_addr = node_q;
				if (go_left_q) begin
					wr_data = {entry_q[ENTRY_W-1:2*IDX_W], count_q[IDX_W-1:0],
						ent_right(entry_q)};
				end else begin
					wr_data = {entry_q[ENTRY_W-1:IDX_W], count_q[IDX_W-1:0]};
				end
			end
			default: begin
			end
		endcase
	end

	kdpi_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_NODES)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_limit_q <= kdpi_pkg::LIMIT_RST;
		end else if (cfg.valid) begin
			node_limit_q <= cfg.node_limit;
		end
	end

	// Payload registers of the walk.
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q        <= query.point_x;
			py_q        <= query.point_y;
			pz_q        <= query.point_z;
			radius_sq_q <= query.radius * query.radius;
		end
		if (state_q == S_READ) begin
			entry_q   <= rd_data;
			go_left_q <= p_axis < e_axis;
		end
	end

	// Walk sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= AXIS_X;
			count_q     <= '0;
			node_q      <= '0;
			out_valid_q <= 1'b0;
			near_q      <= 1'b0;
			ins_q       <= 1'b0;
			full_q      <= 1'b0;
		end else begin
			if (result.ready && !res_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (query.opcode == kdpi_pkg::OP_CLEAR) begin
							count_q     <= '0;
							out_valid_q <= 1'b1;
							near_q      <= 1'b0;
							ins_q       <= 1'b0;
							full_q      <= 1'b0;
						end else if (is_full) begin
							out_valid_q <= 1'b1;
							near_q      <= 1'b0;
							ins_q       <= 1'b0;
							full_q      <= 1'b1;
						end else if (count_q == '0) begin
							count_q     <= CNT_W'(1);
							out_valid_q <= 1'b1;
							near_q      <= 1'b0;
							ins_q       <= 1'b1;
							full_q      <= 1'b0;
						end else begin
							node_q  <= '0;
							axis_q  <= AXIS_X;
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (near_hit) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							near_q      <= 1'b1;
							ins_q       <= 1'b0;
							full_q      <= 1'b0;
							state_q     <= S_IDLE;
						end
					end else if (link == '0) begin
						state_q <= S_LINK;
					end else begin
						node_q  <= link;
						state_q <= S_READ;
						unique case (axis_q)
							AXIS_X:  axis_q <= AXIS_Y;
							AXIS_Y:  axis_q <= AXIS_Z;
							default: axis_q <= AXIS_X;
						endcase
					end
				end
				S_LINK: begin
					if (out_free) begin
						count_q     <= count_q + CNT_W'(1);
						out_valid_q <= 1'b1;
						near_q      <= 1'b0;
						ins_q       <= 1'b1;
						full_q      <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/kdpi_ram.sv]
`timescale 1ns / 1ps

// Simple dual-port RAM with a registered read.
module kdpi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/kdpi_dist.sv]
`timescale 1ns / 1ps

// Squared distance terms between the query point and one node, registered.
module kdpi_dist #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic signed [COORD_BITS-1:0] p_x,
	input  logic signed [COORD_BITS-1:0] p_y,
	input  logic signed [COORD_BITS-1:0] p_z,
	input  logic signed [COORD_BITS-1:0] e_x,
	input  logic signed [COORD_BITS-1:0] e_y,
	input  logic signed [COORD_BITS-1:0] e_z,
	output kdpi_pkg::dist_t              dist_s1
);

	localparam int DW = COORD_BITS + 1;
	localparam int MW = (DW > kdpi_pkg::RADIUS_W) ? DW : kdpi_pkg::RADIUS_W + 1;
	localparam int RW = kdpi_pkg::RADIUS_W;

	logic signed [DW-1:0] dx, dy, dz;
	logic [MW-1:0]        mx, my, mz;
	logic                 far;

	// Axis gaps and their magnitudes.
	always_comb begin
		dx = DW'(e_x) - DW'(p_x);
		dy = DW'(e_y) - DW'(p_y);
		dz = DW'(e_z) - DW'(p_z);
		mx = MW'(dx[DW-1] ? unsigned'(-dx) : unsigned'(dx));
		my = MW'(dy[DW-1] ? unsigned'(-dy) : unsigned'(dy));
		mz = MW'(dz[DW-1] ? unsigned'(-dz) : unsigned'(dz));
		// A gap of 2^16 or more squares above any 16-bit margin squared.
		far = (|mx[MW-1:RW]) || (|my[MW-1:RW]) || (|mz[MW-1:RW]);
	end

	// Narrow squares, registered before they are summed.
	always_ff @(posedge clk) begin
		dist_s1.far  <= far;
		dist_s1.sq_x <= mx[RW-1:0] * mx[RW-1:0];
		dist_s1.sq_y <= my[RW-1:0] * my[RW-1:0];
		dist_s1.sq_z <= mz[RW-1:0] * mz[RW-1:0];
	end

endmodule
